@@ rtl/ffa_pkg.sv @@
// Shared types, constants and codes for the first-fit range allocator.
package ffa_pkg;

    localparam int FREE_SLOTS = 16;
    localparam int INDEX_BITS = 16;
    localparam int CAP_BITS   = 16;
    localparam int SLOT_BITS  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int COUNT_BITS = $clog2(FREE_SLOTS + 1);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_LIST_FULL = 2'd2;

    typedef struct packed {
        logic                  mode;
        logic [INDEX_BITS-1:0] start_index;
        logic [INDEX_BITS-1:0] count;
    } ffa_req_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] alloc_index;
        logic [1:0]            status;
    } ffa_rsp_t;

    // Request data broadcast to every cell while a scan runs.
    typedef struct packed {
        logic                  mode;
        logic [INDEX_BITS-1:0] start_index;
        logic [INDEX_BITS-1:0] count;
        logic [INDEX_BITS:0]   run_end;
    } ffa_cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } ffa_state_t;

endpackage

@@ rtl/ffa_cell.sv @@
// One free-list entry: hole storage, match logic and the scan token stage.
module ffa_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ffa_pkg::ffa_cell_ctl_t         ctl,
    input  logic                           valid,
    input  logic                           tok_in,
    input  logic                           wr_en,
    input  logic                           shift_en,
    input  logic [ffa_pkg::INDEX_BITS-1:0] nb_start,
    input  logic [ffa_pkg::INDEX_BITS-1:0] nb_len,
    output logic                           tok_here,
    output logic                           tok_out,
    output logic                           hit,
    output logic                           exact,
    output logic [ffa_pkg::INDEX_BITS-1:0] hole_start,
    output logic [ffa_pkg::INDEX_BITS-1:0] hole_len
);

    logic                           tok_reg;
    logic [ffa_pkg::INDEX_BITS-1:0] start_reg, start_next;
    logic [ffa_pkg::INDEX_BITS-1:0] len_reg, len_next;
    logic                           match;
    logic [ffa_pkg::INDEX_BITS:0]   sum;

    always_comb
    begin
        if (ctl.mode == ffa_pkg::MODE_ALLOC)
            match = (len_reg >= ctl.count);
        else
            match = ({1'b0, start_reg} == ctl.run_end);
    end

    assign hit      = tok_reg & valid & match;
    assign exact    = (len_reg == ctl.count);
    assign tok_out  = tok_reg & valid & ~match;
    assign tok_here = tok_reg;
    assign hole_start = start_reg;
    assign hole_len   = len_reg;
    assign sum = {1'b0, len_reg} + {1'b0, ctl.count};

    always_comb
    begin
        start_next = start_reg;
        len_next   = len_reg;
        if (wr_en)
        begin
            start_next = ctl.start_index;
            len_next   = ctl.count;
        end
        else if (shift_en)
        begin
            start_next = nb_start;
            len_next   = nb_len;
        end
        else if (hit)
        begin
            if (ctl.mode == ffa_pkg::MODE_FREE)
            begin
                // merge: run sits right in front of this hole
                start_next = ctl.start_index;
                len_next   = sum[ffa_pkg::INDEX_BITS] ? '1 : sum[ffa_pkg::INDEX_BITS-1:0];
            end
            else if (!exact)
            begin
                start_next = start_reg + ctl.count;
                len_next   = len_reg - ctl.count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= 1'b0;
        else
            tok_reg <= tok_in;
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        len_reg   <= len_next;
    end

endmodule

@@ rtl/first_fit_range_allocator.sv @@
// Top level of the first-fit range allocator: control, pointers and the cell chain.
// Sequence: a free ending at the top pointer completes from S_IDLE; any other request
//   enters S_SCAN until the scan token stops at an entry (0 to 15); an exact fit then
//   also passes through S_SHIFT. Throughput: one transaction at a time, its length set
//   by the token walking the chain one entry per cycle. Results are held; done pulses once.
// Reset: asynchronous, active low; top pointer and hole count zero, capacity 65535.
module first_fit_range_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ffa_pkg::ffa_req_t            request,
    input  logic                         cap_we,
    input  logic [ffa_pkg::CAP_BITS-1:0] cap_wdata,
    output logic                         done,
    output ffa_pkg::ffa_rsp_t            result
);

    localparam int N  = ffa_pkg::FREE_SLOTS;
    localparam int IW = ffa_pkg::INDEX_BITS;

    // control state
    ffa_pkg::ffa_state_t             state_reg, state_next;
    logic [ffa_pkg::COUNT_BITS-1:0]  hcnt_reg, hcnt_next;
    logic [IW-1:0]                   top_reg, top_next;
    logic [ffa_pkg::CAP_BITS-1:0]    cap_reg;
    logic                            done_reg, done_next;

    // payload
    ffa_pkg::ffa_req_t               req_reg, req_next;
    logic [IW:0]                     end_reg, end_next;
    logic [ffa_pkg::SLOT_BITS-1:0]   hit_idx_reg, hit_idx_next;
    ffa_pkg::ffa_rsp_t               rsp_reg, rsp_next;

    // chain signals
    ffa_pkg::ffa_cell_ctl_t          cell_ctl;
    logic [N-1:0]                    valid_vec, tok_here_vec, tok_out_vec;
    logic [N-1:0]                    hit_vec, exact_vec, wr_vec, shift_vec;
    logic [N:0]                      tok_chain;
    logic [IW-1:0]                   start_vec [N];
    logic [IW-1:0]                   len_vec   [N];

    // decode
    logic                            accept, top_free_hit, launch;
    logic                            scanning, shift_go, append;
    logic                            hit_any, hit_exact, scan_end;
    logic [IW:0]                     req_end;
    logic [IW-1:0]                   hit_start;
    logic [ffa_pkg::SLOT_BITS-1:0]   hit_idx;
    logic [ffa_pkg::CAP_BITS-1:0]    avail;

    assign req_end = {1'b0, request.start_index} + {1'b0, request.count};

    assign cell_ctl.mode        = req_reg.mode;
    assign cell_ctl.start_index = req_reg.start_index;
    assign cell_ctl.count       = req_reg.count;
    assign cell_ctl.run_end     = end_reg;

    assign tok_chain[0] = launch;

    // --- cell chain: token walks from entry 0 toward entry N-1 ---
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [IW-1:0] nb_start, nb_len;

        if (i == N - 1)
        begin : g_last
            assign nb_start = start_vec[i];
            assign nb_len   = len_vec[i];
        end
        else
        begin : g_mid
            assign nb_start = start_vec[i+1];
            assign nb_len   = len_vec[i+1];
        end

        assign valid_vec[i] = (hcnt_reg > ffa_pkg::COUNT_BITS'(i));
        assign wr_vec[i]    = append && (hcnt_reg == ffa_pkg::COUNT_BITS'(i));
        assign shift_vec[i] = shift_go && (ffa_pkg::SLOT_BITS'(i) >= hit_idx_reg);
        assign tok_chain[i+1] = tok_out_vec[i];

        ffa_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .valid      (valid_vec[i]),
            .tok_in     (tok_chain[i]),
            .wr_en      (wr_vec[i]),
            .shift_en   (shift_vec[i]),
            .nb_start   (nb_start),
            .nb_len     (nb_len),
            .tok_here   (tok_here_vec[i]),
            .tok_out    (tok_out_vec[i]),
            .hit        (hit_vec[i]),
            .exact      (exact_vec[i]),
            .hole_start (start_vec[i]),
            .hole_len   (len_vec[i])
        );
    end

    // One-hot hit: at most one cell holds the token, so OR-muxing is safe.
    always_comb
    begin
        hit_start = '0;
        hit_idx   = '0;
        hit_exact = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if (hit_vec[i])
            begin
                hit_start = hit_start | start_vec[i];
                hit_idx   = hit_idx | ffa_pkg::SLOT_BITS'(i);
                hit_exact = hit_exact | exact_vec[i];
            end
        end
    end

    assign hit_any  = |hit_vec;
    // token died at an empty entry, or fell off the end of the chain
    assign scan_end = (|(tok_here_vec & ~valid_vec)) | tok_out_vec[N-1];
    assign avail    = (top_reg <= cap_reg) ? (cap_reg - top_reg) : '0;

    // --- FSM next state ---
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (launch)
                    state_next = ffa_pkg::S_SCAN;
            end
            ffa_pkg::S_SCAN:
            begin
                if (hit_any && req_reg.mode == ffa_pkg::MODE_ALLOC && hit_exact)
                    state_next = ffa_pkg::S_SHIFT;
                else if (hit_any || scan_end)
                    state_next = ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_SHIFT:
                state_next = ffa_pkg::S_IDLE;
            default:
                state_next = ffa_pkg::S_IDLE;
        endcase
    end

    // --- FSM outputs ---
    always_comb
    begin
        busy         = 1'b1;
        scanning     = 1'b0;
        shift_go     = 1'b0;
        case (state_reg)
            ffa_pkg::S_IDLE:  busy     = 1'b0;
            ffa_pkg::S_SCAN:  scanning = 1'b1;
            ffa_pkg::S_SHIFT: shift_go = 1'b1;
            default:          busy     = 1'b1;
        endcase
        accept       = start && !busy;
        // free of the run just below the top pointer: no scan needed
        top_free_hit = accept && (request.mode == ffa_pkg::MODE_FREE)
                       && (req_end == {1'b0, top_reg});
        launch       = accept && !top_free_hit;
        append       = scanning && scan_end && !hit_any
                       && (req_reg.mode == ffa_pkg::MODE_FREE)
                       && (hcnt_reg < ffa_pkg::COUNT_BITS'(N));
    end

    // --- datapath next values ---
    always_comb
    begin
        req_next     = req_reg;
        end_next     = end_reg;
        hit_idx_next = hit_idx_reg;
        rsp_next     = rsp_reg;
        top_next     = top_reg;
        hcnt_next    = hcnt_reg;
        done_next    = 1'b0;

        if (accept)
        begin
            req_next = request;
            end_next = req_end;
            if (top_free_hit)
            begin
                top_next  = top_reg - request.count;
                rsp_next  = '{alloc_index: '0, status: ffa_pkg::ST_OK};
                done_next = 1'b1;
            end
        end

        if (scanning && hit_any)
        begin
            hit_idx_next = hit_idx;
            done_next    = 1'b1;
            if (req_reg.mode == ffa_pkg::MODE_ALLOC)
                rsp_next = '{alloc_index: hit_start, status: ffa_pkg::ST_OK};
            else
                rsp_next = '{alloc_index: '0, status: ffa_pkg::ST_OK};
        end
        else if (scanning && scan_end)
        begin
            done_next = 1'b1;
            if (req_reg.mode == ffa_pkg::MODE_ALLOC)
            begin
                // no hole fits: bump the top pointer if capacity allows
                if (req_reg.count <= avail)
                begin
                    rsp_next = '{alloc_index: top_reg, status: ffa_pkg::ST_OK};
                    top_next = top_reg + req_reg.count;
                end
                else
                    rsp_next = '{alloc_index: '0, status: ffa_pkg::ST_NO_SPACE};
            end
            else if (append)
            begin
                rsp_next  = '{alloc_index: '0, status: ffa_pkg::ST_OK};
                hcnt_next = hcnt_reg + ffa_pkg::COUNT_BITS'(1);
            end
            else
                rsp_next = '{alloc_index: '0, status: ffa_pkg::ST_LIST_FULL};
        end

        // exact fit: entries from the hit onward move down one place
        if (shift_go)
            hcnt_next = hcnt_reg - ffa_pkg::COUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::S_IDLE;
            hcnt_reg  <= '0;
            top_reg   <= '0;
            cap_reg   <= '1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hcnt_reg  <= hcnt_next;
            top_reg   <= top_next;
            done_reg  <= done_next;
            if (cap_we)
                cap_reg <= cap_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        end_reg     <= end_next;
        hit_idx_reg <= hit_idx_next;
        rsp_reg     <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

@@ rtl/ffa_checker.sv @@
// Port-level checker for the first-fit range allocator, bound to the top level.
module ffa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ffa_pkg::ffa_req_t request,
    input logic              done,
    input ffa_pkg::ffa_rsp_t result
);

    // a result only follows an accepted transaction or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("done without a transaction in flight");

    // an accepted transaction either completes at once or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction vanished");

    // failed requests return index zero
    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ffa_pkg::ST_OK) |-> (result.alloc_index == '0))
        else $error("nonzero index on failed transaction");

    // a free completing straight from acceptance (top-pointer case) never reports out of space
    a_free_status: assert property (@(posedge clk) disable iff (!rst_n)
        ((start && !busy && request.mode == ffa_pkg::MODE_FREE) ##1 done)
            |-> (result.status != ffa_pkg::ST_NO_SPACE))
        else $error("free reported out of space");

endmodule

bind first_fit_range_allocator ffa_checker u_ffa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
